### rtl/fbx_pkg.sv
package fbx_pkg;

	// ALU operations
	localparam logic [1:0] OP_MAC  = 2'd0;
	localparam logic [1:0] OP_HALF = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;
	localparam logic [1:0] OP_END  = 2'd3;

	// operand sources: scratch registers, state read data, input sample, lane value
	localparam logic [3:0] R0     = 4'd0;
	localparam logic [3:0] R1     = 4'd1;
	localparam logic [3:0] R2     = 4'd2;
	localparam logic [3:0] R3     = 4'd3;
	localparam logic [3:0] R4     = 4'd4;
	localparam logic [3:0] R5     = 4'd5;
	localparam logic [3:0] R6     = 4'd6;
	localparam logic [3:0] R7     = 4'd7;
	localparam logic [3:0] SRC_Z  = 4'd8;
	localparam logic [3:0] SRC_IN = 4'd9;
	localparam logic [3:0] SRC_LN = 4'd10;

	// coefficient slot within a set
	localparam logic [1:0] K0 = 2'd0;
	localparam logic [1:0] K1 = 2'd1;
	localparam logic [1:0] K2 = 2'd2;

	// coefficient set: mid cutoff, phase correction set, split set
	localparam logic [1:0] CS_MID = 2'd0;
	localparam logic [1:0] CS_PH  = 2'd1;
	localparam logic [1:0] CS_SP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MID  = 2'd0;
	localparam logic [1:0] REG_LOW  = 2'd1;
	localparam logic [1:0] REG_HIGH = 2'd2;

	localparam int          PC_W      = 6;
	localparam logic [5:0]  PC_BAND   = 6'd17;
	localparam logic [5:0]  PC_END    = 6'd40;
	localparam int          MEM_AW    = 7;
	localparam int          MEM_DEPTH = 128;
	localparam int          NREG      = 8;
	localparam int          NLANE     = 4;
	localparam int          NOUT      = 8;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] src_a;
		logic [3:0] src_c;
		logic [1:0] kidx;
		logic       kneg;
		logic [1:0] cset;
		logic       dst_en;
		logic [2:0] dst;
		logic       rd;
		logic       wr;
		logic [3:0] off;
		logic       lwr;
		logic       owr;
		logic       hi;
		logic       lp;
		logic [5:0] tgt;
	} uword_t;

	function automatic uword_t uw(logic [1:0] op, logic [3:0] a, logic [3:0] c, logic [1:0] k,
		logic kn, logic [1:0] cs, logic de, logic [3:0] d, logic rd, logic wr, logic [3:0] off,
		logic lw, logic ow, logic hi, logic lp, logic [5:0] tgt);
		uword_t w;
		w.op     = op;
		w.src_a  = a;
		w.src_c  = c;
		w.kidx   = k;
		w.kneg   = kn;
		w.cset   = cs;
		w.dst_en = de;
		w.dst    = d[2:0];
		w.rd     = rd;
		w.wr     = wr;
		w.off    = off;
		w.lwr    = lw;
		w.owr    = ow;
		w.hi     = hi;
		w.lp     = lp;
		w.tgt    = tgt;
		return w;
	endfunction

	// multiply-accumulate step
	function automatic uword_t um(logic [3:0] a, logic [3:0] c, logic [1:0] k, logic kn,
		logic [1:0] cs, logic de, logic [3:0] d, logic rd, logic wr, logic [3:0] off);
		return uw(OP_MAC, a, c, k, kn, cs, de, d, rd, wr, off, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
	endfunction

	// program: mid split per channel (steps 0..16), then per lane phase fix and split
	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			// first S stage, A1 on input
			6'd0:  w = um(SRC_Z, SRC_IN, K0, 1'b1, CS_MID, 1'b1, R1, 1'b1, 1'b1, 4'd0);
			6'd1:  w = um(R1, SRC_Z, K0, 1'b0, CS_MID, 1'b1, R0, 1'b0, 1'b0, 4'd0);
			// A2 on input
			6'd2:  w = um(SRC_IN, SRC_Z, K2, 1'b0, CS_MID, 1'b1, R2, 1'b1, 1'b0, 4'd1);
			6'd3:  w = um(SRC_IN, SRC_Z, K1, 1'b0, CS_MID, 1'b1, R3, 1'b1, 1'b0, 4'd2);
			6'd4:  w = um(R2, R3, K1, 1'b1, CS_MID, 1'b0, R0, 1'b0, 1'b1, 4'd1);
			6'd5:  w = um(R2, SRC_IN, K2, 1'b1, CS_MID, 1'b0, R0, 1'b0, 1'b1, 4'd2);
			6'd6:  w = uw(OP_HALF, R0, R2, K0, 1'b0, CS_MID, 1'b1, R4, 1'b0, 1'b0, 4'd0,
				1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
			// second S stage
			6'd7:  w = um(SRC_Z, R4, K0, 1'b1, CS_MID, 1'b1, R1, 1'b1, 1'b1, 4'd3);
			6'd8:  w = um(R1, SRC_Z, K0, 1'b0, CS_MID, 1'b1, R0, 1'b0, 1'b0, 4'd3);
			6'd9:  w = um(R4, SRC_Z, K2, 1'b0, CS_MID, 1'b1, R5, 1'b1, 1'b0, 4'd4);
			6'd10: w = um(R4, SRC_Z, K1, 1'b0, CS_MID, 1'b1, R3, 1'b1, 1'b0, 4'd5);
			6'd11: w = um(R5, R3, K1, 1'b1, CS_MID, 1'b0, R0, 1'b0, 1'b1, 4'd4);
			6'd12: w = um(R5, R4, K2, 1'b1, CS_MID, 1'b0, R0, 1'b0, 1'b1, 4'd5);
			6'd13: w = uw(OP_HALF, R0, R5, K0, 1'b0, CS_MID, 1'b1, R4, 1'b0, 1'b0, 4'd0,
				1'b1, 1'b0, 1'b0, 1'b0, 6'd0);
			// serial A1 on the first A2 output, high = serial - low
			6'd14: w = um(SRC_Z, R2, K0, 1'b1, CS_MID, 1'b1, R1, 1'b1, 1'b1, 4'd6);
			6'd15: w = um(R1, SRC_Z, K0, 1'b0, CS_MID, 1'b1, R0, 1'b0, 1'b0, 4'd6);
			6'd16: w = uw(OP_SUB, R0, R4, K0, 1'b0, CS_MID, 1'b0, R0, 1'b0, 1'b0, 4'd0,
				1'b1, 1'b0, 1'b1, 1'b1, 6'd0);
			// phase correction A1 then A2, result in R7
			6'd17: w = um(SRC_Z, SRC_LN, K0, 1'b1, CS_PH, 1'b1, R1, 1'b1, 1'b1, 4'd0);
			6'd18: w = um(R1, SRC_Z, K0, 1'b0, CS_PH, 1'b1, R6, 1'b0, 1'b0, 4'd0);
			6'd19: w = um(R6, SRC_Z, K2, 1'b0, CS_PH, 1'b1, R7, 1'b1, 1'b0, 4'd1);
			6'd20: w = um(R6, SRC_Z, K1, 1'b0, CS_PH, 1'b1, R3, 1'b1, 1'b0, 4'd2);
			6'd21: w = um(R7, R3, K1, 1'b1, CS_PH, 1'b0, R0, 1'b0, 1'b1, 4'd1);
			6'd22: w = um(R7, R6, K2, 1'b1, CS_PH, 1'b0, R0, 1'b0, 1'b1, 4'd2);
			// band split, first S stage
			6'd23: w = um(SRC_Z, R7, K0, 1'b1, CS_SP, 1'b1, R1, 1'b1, 1'b1, 4'd3);
			6'd24: w = um(R1, SRC_Z, K0, 1'b0, CS_SP, 1'b1, R0, 1'b0, 1'b0, 4'd3);
			6'd25: w = um(R7, SRC_Z, K2, 1'b0, CS_SP, 1'b1, R2, 1'b1, 1'b0, 4'd4);
			6'd26: w = um(R7, SRC_Z, K1, 1'b0, CS_SP, 1'b1, R3, 1'b1, 1'b0, 4'd5);
			6'd27: w = um(R2, R3, K1, 1'b1, CS_SP, 1'b0, R0, 1'b0, 1'b1, 4'd4);
			6'd28: w = um(R2, R7, K2, 1'b1, CS_SP, 1'b0, R0, 1'b0, 1'b1, 4'd5);
			6'd29: w = uw(OP_HALF, R0, R2, K0, 1'b0, CS_SP, 1'b1, R4, 1'b0, 1'b0, 4'd0,
				1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
			// band split, second S stage
			6'd30: w = um(SRC_Z, R4, K0, 1'b1, CS_SP, 1'b1, R1, 1'b1, 1'b1, 4'd6);
			6'd31: w = um(R1, SRC_Z, K0, 1'b0, CS_SP, 1'b1, R0, 1'b0, 1'b0, 4'd6);
			6'd32: w = um(R4, SRC_Z, K2, 1'b0, CS_SP, 1'b1, R5, 1'b1, 1'b0, 4'd7);
			6'd33: w = um(R4, SRC_Z, K1, 1'b0, CS_SP, 1'b1, R3, 1'b1, 1'b0, 4'd8);
			6'd34: w = um(R5, R3, K1, 1'b1, CS_SP, 1'b0, R0, 1'b0, 1'b1, 4'd7);
			6'd35: w = um(R5, R4, K2, 1'b1, CS_SP, 1'b0, R0, 1'b0, 1'b1, 4'd8);
			6'd36: w = uw(OP_HALF, R0, R5, K0, 1'b0, CS_SP, 1'b1, R4, 1'b0, 1'b0, 4'd0,
				1'b0, 1'b1, 1'b0, 1'b0, 6'd0);
			// serial A1 and band high output
			6'd37: w = um(SRC_Z, R2, K0, 1'b1, CS_SP, 1'b1, R1, 1'b1, 1'b1, 4'd9);
			6'd38: w = um(R1, SRC_Z, K0, 1'b0, CS_SP, 1'b1, R0, 1'b0, 1'b0, 4'd9);
			6'd39: w = uw(OP_SUB, R0, R4, K0, 1'b0, CS_SP, 1'b0, R0, 1'b0, 1'b0, 4'd0,
				1'b0, 1'b1, 1'b1, 1'b1, PC_BAND);
			default: w = uw(OP_END, R0, R0, K0, 1'b0, CS_MID, 1'b0, R0, 1'b0, 1'b0, 4'd0,
				1'b0, 1'b0, 1'b0, 1'b0, 6'd0);
		endcase
		return w;
	endfunction

endpackage

### rtl/fbx_alu.sv
// Shared arithmetic unit: rounded multiply-accumulate, halving sum, difference,
// all saturated to the internal width.
module fbx_alu #(
	parameter int IW = 32,
	parameter int CW = 16
) (
	input  logic [1:0]           op,
	input  logic                 kneg,
	input  logic signed [IW-1:0] a,
	input  logic signed [IW-1:0] c,
	input  logic signed [CW-1:0] k,
	output logic signed [IW-1:0] res
);

	localparam int PW = IW + CW + 2;
	localparam logic signed [PW-1:0] RND  = PW'(1) <<< (CW - 3);
	localparam logic signed [PW-1:0] MAXV = (PW'(1) <<< (IW - 1)) - PW'(1);
	localparam logic signed [PW-1:0] MINV = -(PW'(1) <<< (IW - 1));

	logic signed [CW:0]   kx;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] wide;

	// exact negation with one extra bit
	assign kx   = kneg ? -((CW + 1)'(k)) : (CW + 1)'(k);
	assign prod = PW'(a) * PW'(kx);

	always_comb begin
		case (op)
			fbx_pkg::OP_MAC:  wide = ((prod + RND) >>> (CW - 2)) + PW'(c);
			fbx_pkg::OP_HALF: wide = (PW'(a) + PW'(c)) >>> 1;
			fbx_pkg::OP_SUB:  wide = PW'(a) - PW'(c);
			default:          wide = PW'(a);
		endcase
	end

	// saturate to internal width
	always_comb begin
		if (wide > MAXV) begin
			res = MAXV[IW-1:0];
		end else if (wide < MINV) begin
			res = MINV[IW-1:0];
		end else begin
			res = wide[IW-1:0];
		end
	end

endmodule

### rtl/four_band_allpass_crossover.sv
// Channel   Dir  Fields (lowest bits first)
// s_axis    in   tdata: left_in, right_in
// m_axis    out  tdata: band1_left, band1_right, band2_left, band2_right,
//                       band3_left, band3_right, band4_left, band4_right
// cfg       in   cfg_addr 0 mid, 1 low, 2 high cutoff coefficients
//
// Each stereo beat runs 126 program steps on one shared multiply-accumulate; each
// of the 54 state reads from the single-port state memory adds a read phase before
// its step, and the end step and the handoff to the output register follow. A new
// beat is accepted only once the previous one has left the program and been handed off.
// Reset clears coefficients, control and the per-entry valid bits of the state
// memory, so every filter delay reads as zero until first written.
// A finished result waits in the output register; a new beat is accepted while it
// is stalled, and a second finished result waits until the first is taken.
module four_band_allpass_crossover #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_WIDTH     = 16,
	parameter int INTERNAL_WIDTH = 32
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // left_in, right_in
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [((8*SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // band1_left .. band4_right
	input  logic                                     cfg_wen,
	input  logic [1:0]                               cfg_addr,
	input  logic [3*COEF_WIDTH-1:0]                  cfg_wdata
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CW  = COEF_WIDTH;
	localparam int IW  = INTERNAL_WIDTH;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	localparam logic signed [IW-1:0] SMAX = IW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [IW-1:0] SMIN = IW'(-(64'sd1 <<< (SW - 1)));

	logic [1:0]                    state_q;
	logic [fbx_pkg::PC_W-1:0]      pc_q;
	logic [1:0]                    lane_q;
	logic                          ph_q;
	logic                          out_v_q;
	logic [3*CW-1:0]               cfg_q [3];
	logic signed [SW-1:0]          in_q [2];
	logic signed [IW-1:0]          rf_q [fbx_pkg::NREG];
	logic signed [IW-1:0]          ln_q [fbx_pkg::NLANE];
	logic signed [SW-1:0]          wk_q [fbx_pkg::NOUT];
	logic signed [SW-1:0]          out_q [fbx_pkg::NOUT];
	logic signed [IW-1:0]          z_q;
	logic signed [IW-1:0]          mem [fbx_pkg::MEM_DEPTH];
	logic [fbx_pkg::MEM_DEPTH-1:0] vld_q;

	fbx_pkg::uword_t               w;
	logic                          run;
	logic                          rd_cyc;
	logic                          ex_cyc;
	logic                          s_fire;
	logic                          load_out;
	logic [1:0]                    last_lane;
	logic [fbx_pkg::MEM_AW-1:0]    addr;
	logic [3*CW-1:0]               kset;
	logic signed [CW-1:0]          kval;
	logic signed [IW-1:0]          opa;
	logic signed [IW-1:0]          opc;
	logic signed [IW-1:0]          res;
	logic signed [SW-1:0]          res_s;

	// control word and cycle kinds
	assign w         = fbx_pkg::ucode(pc_q);
	assign run       = (state_q == S_RUN) && (w.op != fbx_pkg::OP_END);
	assign rd_cyc    = run && w.rd && !ph_q;
	assign ex_cyc    = run && !rd_cyc;
	assign last_lane = (w.cset == fbx_pkg::CS_MID) ? 2'd1 : 2'd3;
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign load_out  = (state_q == S_DONE) && (!out_v_q || m_axis_tready);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;

	// state memory address: mid region per channel, band region per lane
	assign addr = (w.cset == fbx_pkg::CS_MID) ? {3'b000, lane_q[0], w.off[2:0]}
		: {1'b1, lane_q, w.off};

	// coefficient set: phase uses the other branch's cutoff, split uses its own
	always_comb begin
		case (w.cset)
			fbx_pkg::CS_MID: kset = cfg_q[fbx_pkg::REG_MID];
			fbx_pkg::CS_PH:  kset = lane_q[1] ? cfg_q[fbx_pkg::REG_LOW] : cfg_q[fbx_pkg::REG_HIGH];
			fbx_pkg::CS_SP:  kset = lane_q[1] ? cfg_q[fbx_pkg::REG_HIGH] : cfg_q[fbx_pkg::REG_LOW];
			default:         kset = cfg_q[fbx_pkg::REG_MID];
		endcase
	end

	always_comb begin
		case (w.kidx)
			fbx_pkg::K0: kval = kset[CW-1:0];
			fbx_pkg::K1: kval = kset[2*CW-1:CW];
			fbx_pkg::K2: kval = kset[3*CW-1:2*CW];
			default:     kval = kset[CW-1:0];
		endcase
	end

	// operand select
	function automatic logic signed [IW-1:0] pick(logic [3:0] src);
		logic signed [IW-1:0] v;
		if (!src[3]) begin
			v = rf_q[src[2:0]];
		end else begin
			case (src)
				fbx_pkg::SRC_Z:  v = z_q;
				fbx_pkg::SRC_IN: v = IW'(in_q[lane_q[0]]);
				fbx_pkg::SRC_LN: v = ln_q[lane_q];
				default:         v = '0;
			endcase
		end
		return v;
	endfunction

	always_comb opa = pick(w.src_a);
	always_comb opc = pick(w.src_c);

	fbx_alu #(.IW(IW), .CW(CW)) u_alu (
		.op  (w.op),
		.kneg(w.kneg),
		.a   (opa),
		.c   (opc),
		.k   (kval),
		.res (res)
	);

	// saturate to sample range
	always_comb begin
		if (res > SMAX) begin
			res_s = SMAX[SW-1:0];
		end else if (res < SMIN) begin
			res_s = SMIN[SW-1:0];
		end else begin
			res_s = res[SW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			lane_q  <= '0;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						state_q <= S_RUN;
						pc_q    <= '0;
						lane_q  <= '0;
						ph_q    <= 1'b0;
					end
				end
				S_RUN: begin
					if (w.op == fbx_pkg::OP_END) begin
						state_q <= S_DONE;
					end else if (rd_cyc) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (w.lp && (lane_q != last_lane)) begin
							lane_q <= lane_q + 2'd1;
							pc_q   <= w.tgt;
						end else begin
							if (w.lp) begin
								lane_q <= '0;
							end
							pc_q <= pc_q + 6'd1;
						end
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output valid and coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			cfg_q[0] <= '0;
			cfg_q[1] <= '0;
			cfg_q[2] <= '0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (cfg_wen && (cfg_addr == fbx_pkg::REG_MID || cfg_addr == fbx_pkg::REG_LOW
				|| cfg_addr == fbx_pkg::REG_HIGH)) begin
				cfg_q[cfg_addr] <= cfg_wdata;
			end
		end
	end

	// state memory valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ex_cyc && w.wr) begin
			vld_q[addr] <= 1'b1;
		end
	end

	// state memory: registered read, write of the step result
	always_ff @(posedge clk) begin
		if (rd_cyc) begin
			z_q <= vld_q[addr] ? mem[addr] : '0;
		end
		if (ex_cyc && w.wr) begin
			mem[addr] <= res;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			in_q[0] <= s_axis_tdata[SW-1:0];
			in_q[1] <= s_axis_tdata[2*SW-1:SW];
		end
		if (ex_cyc && w.dst_en) begin
			rf_q[w.dst] <= res;
		end
		if (ex_cyc && w.lwr) begin
			ln_q[{w.hi, lane_q[0]}] <= res;
		end
		if (ex_cyc && w.owr) begin
			wk_q[{lane_q[1], w.hi, lane_q[0]}] <= res_s;
		end
		if (load_out) begin
			out_q <= wk_q;
		end
	end

	// pack result beat
	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < fbx_pkg::NOUT; i++) begin
			m_axis_tdata[i*SW +: SW] = out_q[i];
		end
	end

	// a state read is always followed by the step that uses it
	a_read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q |=> !ph_q)
		else $error("state read not followed by its step");

	// the program counter stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (pc_q <= fbx_pkg::PC_END))
		else $error("program counter out of range");

	// the mid split runs over two channels only
	a_mid_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(run && w.cset == fbx_pkg::CS_MID) |-> (lane_q <= 2'd1))
		else $error("mid split lane out of range");

	// a new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_v_q || m_axis_tready))
		else $error("pending result overwritten");

	// an accepted beat starts the program at its first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == S_RUN && pc_q == '0 && lane_q == 2'd0))
		else $error("program did not start");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// Scoreboard: bit-accurate crossover predictor plus queue of expected band beats
class crossover_scoreboard;
	typedef logic signed [63:0] s64_t;

	s64_t coef_k0[3], coef_k1[3], coef_k2[3];
	s64_t mid_z1[6], mid_z2[8], ph_z1[4], ph_z2[8], sp_z1[12], sp_z2[16];
	logic [191:0] band_q[$];
	int unsigned n_err;
	int unsigned n_checked;

	function void clear();
		foreach (coef_k0[i]) begin
			coef_k0[i] = 0; coef_k1[i] = 0; coef_k2[i] = 0;
		end
		foreach (mid_z1[i]) mid_z1[i] = 0;
		foreach (mid_z2[i]) mid_z2[i] = 0;
		foreach (ph_z1[i]) ph_z1[i] = 0;
		foreach (ph_z2[i]) ph_z2[i] = 0;
		foreach (sp_z1[i]) sp_z1[i] = 0;
		foreach (sp_z2[i]) sp_z2[i] = 0;
		band_q.delete();
		n_err = 0;
		n_checked = 0;
	endfunction

	function void write_coefs(logic [1:0] idx, logic [47:0] val);
		if (idx > fbx_pkg::REG_HIGH) return;
		coef_k0[idx] = s64_t'(signed'(val[15:0]));
		coef_k1[idx] = s64_t'(signed'(val[31:16]));
		coef_k2[idx] = s64_t'(signed'(val[47:32]));
	endfunction

	function s64_t clip(s64_t x, int w);
		s64_t lim;
		lim = s64_t'(1) <<< (w - 1);
		if (x > lim - 1) return lim - 1;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// a*k rounded half up to sample scale, plus c, clipped to internal width
	function s64_t mac(s64_t a, s64_t k, s64_t c);
		s64_t p;
		p = (a * k + 64'sd8192) >>> 14;
		return clip(p + c, 32);
	endfunction

	function s64_t halve(s64_t a, s64_t b);
		return clip((a + b) >>> 1, 32);
	endfunction

	function s64_t lattice1(s64_t x, int cs, ref s64_t z);
		s64_t v, y;
		v = mac(z, -coef_k0[cs], x);
		y = mac(v, coef_k0[cs], z);
		z = v;
		return y;
	endfunction

	function s64_t section2(s64_t x, int cs, ref s64_t z1, ref s64_t z2);
		s64_t y, t;
		y = mac(x, coef_k2[cs], z1);
		t = mac(x, coef_k1[cs], z2);
		z1 = mac(y, -coef_k1[cs], t);
		z2 = mac(y, -coef_k2[cs], x);
		return y;
	endfunction

	function void note_input(logic [47:0] din);
		s64_t lane[4];
		s64_t x, a1, a2, s, b1, b2, lo, ser, hi, p;
		logic [23:0] band[8];
		logic [191:0] packed_out;
		int cp, cs, base, c;
		for (c = 0; c < 2; c++) begin
			x = (c == 0) ? s64_t'(signed'(din[23:0])) : s64_t'(signed'(din[47:24]));
			a1 = lattice1(x, fbx_pkg::REG_MID, mid_z1[c]);
			a2 = section2(x, fbx_pkg::REG_MID, mid_z2[c], mid_z2[2 + c]);
			s = halve(a1, a2);
			b1 = lattice1(s, fbx_pkg::REG_MID, mid_z1[2 + c]);
			b2 = section2(s, fbx_pkg::REG_MID, mid_z2[4 + c], mid_z2[6 + c]);
			lo = halve(b1, b2);
			ser = lattice1(a2, fbx_pkg::REG_MID, mid_z1[4 + c]);
			lane[c] = lo;
			lane[2 + c] = clip(ser - lo, 32);
		end
		// phase fix with the other cutoff, then split
		for (int l = 0; l < 4; l++) begin
			cp = (l < 2) ? fbx_pkg::REG_HIGH : fbx_pkg::REG_LOW;
			cs = (l < 2) ? fbx_pkg::REG_LOW : fbx_pkg::REG_HIGH;
			base = (l < 2) ? 0 : 4;
			p = lattice1(lane[l], cp, ph_z1[l]);
			p = section2(p, cp, ph_z2[l], ph_z2[4 + l]);
			a1 = lattice1(p, cs, sp_z1[l]);
			a2 = section2(p, cs, sp_z2[l], sp_z2[4 + l]);
			s = halve(a1, a2);
			b1 = lattice1(s, cs, sp_z1[4 + l]);
			b2 = section2(s, cs, sp_z2[8 + l], sp_z2[12 + l]);
			lo = halve(b1, b2);
			ser = lattice1(a2, cs, sp_z1[8 + l]);
			hi = clip(ser - lo, 32);
			band[base + (l & 1)] = 24'(clip(lo, 24));
			band[base + 2 + (l & 1)] = 24'(clip(hi, 24));
		end
		for (int i = 0; i < 8; i++) packed_out[i*24 +: 24] = band[i];
		band_q.push_back(packed_out);
	endfunction

	function void check_result(logic [191:0] dout);
		logic [191:0] exp_v;
		if (band_q.size() == 0) begin
			$error("band beat with no expectation: %h", dout);
			n_err++;
			return;
		end
		exp_v = band_q.pop_front();
		n_checked++;
		for (int i = 0; i < 8; i++)
			if (dout[i*24 +: 24] !== exp_v[i*24 +: 24]) begin
				$error("band%0d_%s: expected %0d actual %0d", i / 2 + 1,
					(i % 2) ? "right" : "left", signed'(exp_v[i*24 +: 24]),
					signed'(dout[i*24 +: 24]));
				n_err++;
			end
	endfunction
endclass

module testbench;

	localparam int  LATENCY   = 200;
	localparam int  WDOG_MAX  = 20000;
	localparam int  N_RANDOM  = 1330;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [191:0] m_axis_tdata;
	logic         cfg_wen;
	logic [1:0]   cfg_addr;
	logic [47:0]  cfg_wdata;

	crossover_scoreboard sb;
	int unsigned idle_cycles = 0;
	int unsigned n_sent;
	bit          long_hold;   // receiver stalls for a long stretch

	four_band_allpass_crossover u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 8);
		return $urandom_range(50, 400);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_coefs(idx, val);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [47:0] d);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(d);
		n_sent++;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.band_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 7))
			0: return 16'h8000;               // -2.0, negation gives +2.0
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h4000;               // 1.0
			4: return 16'hc000;
			default: return 16'($urandom_range(0, 32767)) - 16'd16384;  // within +-1
		endcase
	endfunction

	task automatic random_phase(int n);
		int g;
		for (int i = 0; i < n; i++) begin
			g = gap_len();
			repeat (g) @(posedge clk);
			send_sample({rand_sample(), rand_sample()});
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 0;
			end else if ($urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// result checking
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

	// watchdog on accept-free cycles
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		sb = new();
		sb.clear();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wen       = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		n_sent        = 0;
		long_hold     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero coefficients after reset
		send_sample({24'h7fffff, 24'h800000});
		send_sample({24'h000001, 24'hffffff});
		drain();

		// typical crossover coefficients
		write_reg(fbx_pkg::REG_MID,  {16'h3000, 16'hc800, 16'h2000});
		write_reg(fbx_pkg::REG_LOW,  {16'h3c00, 16'h8400, 16'h3a00});
		write_reg(fbx_pkg::REG_HIGH, {16'h1000, 16'h1800, 16'h0800});
		// impulse, full-scale steps, sign flips
		send_sample({24'h000000, 24'h7fffff});
		repeat (4) send_sample('0);
		repeat (4) send_sample({24'h7fffff, 24'h7fffff});
		repeat (4) send_sample({24'h800000, 24'h800000});
		send_sample({24'h800000, 24'h7fffff});
		send_sample({24'h7fffff, 24'h800000});
		drain();

		// extreme coefficients drive internal saturation; -2.0 negated exactly
		write_reg(fbx_pkg::REG_MID,  {16'h8000, 16'h8000, 16'h8000});
		write_reg(fbx_pkg::REG_LOW,  {16'h7fff, 16'h7fff, 16'h7fff});
		write_reg(fbx_pkg::REG_HIGH, {16'h8000, 16'h7fff, 16'h8000});
		repeat (3) send_sample({24'h7fffff, 24'h800000});
		repeat (2) send_sample({24'h800000, 24'h7fffff});
		drain();
		// out-of-range index is ignored
		write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
		random_phase(40);

		// long receiver hold-off while samples keep coming
		long_hold = 1;
		for (int i = 0; i < 8; i++) send_sample({rand_sample(), rand_sample()});
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(fbx_pkg::REG_MID,  {rand_coef(), rand_coef(), rand_coef()});
			write_reg(fbx_pkg::REG_LOW,  {rand_coef(), rand_coef(), rand_coef()});
			write_reg(fbx_pkg::REG_HIGH, {rand_coef(), rand_coef(), rand_coef()});
			random_phase((N_RANDOM - 48) / 6);
			drain();   // sender pauses until every band beat is back
		end

		if (sb.n_err == 0 && sb.band_q.size() == 0) begin
			$display("Ran %0d stereo samples over nine coefficient settings,", n_sent);
			$display("%0d band beats checked, with saturation and stalls.", sb.n_checked);
			$display("PASS");
		end else begin
			$display("Ran %0d samples, %0d mismatches, %0d beats missing.", n_sent,
				sb.n_err, sb.band_q.size());
			$display("FAIL");
		end
		$finish;
	end
endmodule

### four_band_allpass_crossover.f
rtl/fbx_pkg.sv
rtl/fbx_alu.sv
rtl/four_band_allpass_crossover.sv
tb/testbench.sv
